// ===== design/lmp_pkg.sv =====
package lmp_pkg;

  // field widths
  localparam int LAT_W    = 30;
  localparam int LON_W    = 31;
  localparam int PIX_W    = 30;
  localparam int ZOOM_W   = 5;
  localparam int SHIFT_W  = 5;
  localparam int MAX_ZOOM = 22;
  localparam int TILE_LOG = 8;
  localparam int FRAC     = 44;

  // pipelined cordic length
  localparam int CORDIC_ITERATIONS = 32;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [ZOOM_W-1:0] ZOOM_RESET = ZOOM_W'(1);

  // degrees scaled by 2^22
  localparam logic [LAT_W-1:0] LAT_POLE = LAT_W'(90 * 4194304);
  localparam logic [31:0]      LON_HALF = 32'(180 * 4194304);
  localparam logic [LON_W-1:0] LON_FULL = LON_W'(360 * 4194304);

  localparam logic [63:0] ONE60 = 64'd1 << 60;

  // shift-subtract divide of constants, quotient over remainder
  function automatic logic [127:0] udivmod(input logic [63:0] a, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return {q, r[63:0]};
  endfunction

  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] d);
    logic [127:0] qr;
    qr = udivmod(a, d);
    return qr[127:64];
  endfunction

  // arctangent or area tangent of 1/n as a 2^60 series
  function automatic logic [63:0] series(input logic [63:0] n, input logic alternate);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    logic        neg;
    p   = udiv(ONE60, n);
    sum = '0;
    neg = 1'b0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        t   = udiv(p, 64'(2 * k + 1));
        sum = neg ? sum - t : sum + t;
        if (alternate) neg = !neg;
        p   = udiv(udiv(p, n), n);
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] to_q44(input logic [63:0] v);
    return (v + 64'd32768) >> 16;
  endfunction

  localparam logic [63:0] QP = (64'd4 * series(64'd5, 1'b1)) - series(64'd239, 1'b1);

  function automatic logic [63:0] atan_q(input int i);
    if (i == 0) return to_q44(QP);
    return to_q44(series(64'd1 << i, 1'b1));
  endfunction

  function automatic logic [63:0] atanh_q(input int i);
    if (i == 0) return 64'd0;
    return to_q44(series(64'd1 << i, 1'b0));
  endfunction

  // hyperbolic shift for a step, with the repeated steps 4, 13, 40
  function automatic int hyp_shift(input int step);
    int  sh;
    int  rep;
    logic again;
    sh    = 1;
    rep   = 4;
    again = 1'b0;
    for (int j = 0; j < step; j++) begin
      if (sh == rep && !again) begin
        again = 1'b1;
      end else begin
        if (sh == rep) begin
          rep   = 3 * rep + 1;
          again = 1'b0;
        end
        sh = sh + 1;
      end
    end
    return sh % 64;
  endfunction

  // fractional quotient a/d with extra bits
  function automatic logic [63:0] div_frac(input logic [63:0] a, input logic [63:0] d,
                                           input int bits);
    logic [127:0] qr;
    logic [63:0]  q;
    logic [63:0]  r;
    qr = udivmod(a, d);
    q  = qr[127:64];
    r  = qr[63:0];
    for (int i = 0; i < bits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r    = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam logic [63:0] QUARTER_PI_Q = to_q44(QP);
  localparam logic [63:0] LN2_Q        = to_q44(64'd2 * series(64'd3, 1'b0));
  localparam logic [63:0] DEG2RAD_Q64  = udiv(QP << 4, 64'd45);
  localparam logic [63:0] INV2PI_Q64   = div_frac(ONE60, QP, 61);
  // floor(2^36 / 45) for the column divide
  localparam logic [30:0] COL_RECIP    = 31'(udiv(64'd1 << 36, 64'd45));
  localparam logic [7:0]  COL_DIV      = 8'd45;

  // classified word passed from front to back
  typedef struct packed {
    logic             coord_valid;
    logic             north;
    logic             polar;
    logic [28:0]      la;
    logic [LON_W-1:0] n_lon;
    logic             col_lo;
    logic             col_hi;
  } lmp_item_t;

  // side data riding along the back pipeline
  typedef struct packed {
    logic             coord_valid;
    logic             north;
    logic             polar;
    logic             col_clip;
    logic [PIX_W-1:0] px;
    logic [2:0]       k;
    logic             bad;
  } lmp_side_t;

endpackage

// ===== design/lmp_if.sv =====
interface lmp_in_if;
  import lmp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] latitude;
  logic signed [LON_W-1:0] longitude;
  logic                    coord_valid;

  modport source (output valid, latitude, longitude, coord_valid, input ready);
  modport sink (input valid, latitude, longitude, coord_valid, output ready);
endinterface

interface lmp_out_if;
  import lmp_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  logic             result_valid;
  logic             clipped;

  modport source (output valid, pixel_x, pixel_y, result_valid, clipped, input ready);
  modport sink (input valid, pixel_x, pixel_y, result_valid, clipped, output ready);
endinterface

// ===== design/lmp_front.sv =====
module lmp_front (
  input  logic               clk,
  input  logic               rst_n,
  lmp_in_if.sink             in_ch,
  output lmp_pkg::lmp_item_t item,
  output logic               push,
  input  logic               full
);
  import lmp_pkg::*;

  logic             f_v_r;
  lmp_item_t        item_r;
  lmp_item_t        item_nxt;
  logic [LAT_W-1:0] lat_u;
  logic [LAT_W-1:0] la;
  logic [31:0]      n_full;
  logic             in_fire;

  assign in_ch.ready = !f_v_r || !full;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign push        = f_v_r && !full;
  assign item        = item_r;

  // classify latitude side, pole and column range
  always_comb begin
    lat_u  = in_ch.latitude;
    la     = lat_u[LAT_W-1] ? (~lat_u + LAT_W'(1)) : lat_u;
    n_full = LON_HALF + {in_ch.longitude[LON_W-1], in_ch.longitude};
    item_nxt.coord_valid = in_ch.coord_valid;
    item_nxt.north       = !lat_u[LAT_W-1] && (lat_u != '0);
    item_nxt.polar       = la >= LAT_POLE;
    item_nxt.la          = la[28:0];
    item_nxt.n_lon       = n_full[LON_W-1:0];
    item_nxt.col_lo      = n_full[31];
    item_nxt.col_hi      = !n_full[31] && (n_full[LON_W-1:0] >= LON_FULL);
  end

  // word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (in_fire) begin
      f_v_r <= 1'b1;
    end else if (push) begin
      f_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== design/lmp_fifo.sv =====
module lmp_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lmp_pkg::lmp_item_t push_item,
  output logic               full,
  input  logic               pop,
  output lmp_pkg::lmp_item_t head,
  output logic               empty
);
  import lmp_pkg::*;

  lmp_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;

  assign full  = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      if (push && !pop) begin
        cnt_r <= cnt_r + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (FIFO_AW+1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/lmp_back.sv =====
module lmp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lmp_pkg::SHIFT_W-1:0] map_shift,
  input  lmp_pkg::lmp_item_t          head,
  input  logic                        empty,
  output logic                        pop,
  lmp_out_if.source                   out_ch
);
  import lmp_pkg::*;

  localparam int N      = CORDIC_ITERATIONS;
  localparam int LAST   = 2 * N + 8;
  localparam int S_COL  = 3;
  localparam int S_K    = N + 3;
  localparam logic signed [65:0] HALF_Q = 66'sd1 <<< (FRAC - 1);
  localparam logic signed [65:0] ONE_Q  = 66'sd1 <<< FRAC;

  logic adv;
  logic [LAST:0] vld_r;
  logic          out_v_r;
  lmp_side_t     side_r [LAST+1];
  lmp_side_t     side0_nxt;
  lmp_side_t     side_col_nxt;
  lmp_side_t     side_k_nxt;

  // column path
  logic [35:0] c_q_r, c_q1_r, c_q2_r;
  logic        c_lo_r, c_lo1_r, c_lo2_r;
  logic        c_hi_r, c_hi1_r, c_hi2_r;
  logic [62:0] c_pl_r;
  logic [34:0] c_ph_r;
  logic [30:0] c_est_r;
  logic [60:0] n_sh;
  logic [67:0] c_sum;
  logic [37:0] c_rem;
  logic [37:0] est45;
  logic [30:0] px_div;
  logic [PIX_W-1:0] size_m1;

  // angle and rotation path
  logic [60:0] r_pl_r;
  logic [56:0] r_ph_r;
  logic [88:0] r_psum;
  logic signed [63:0] rx_r [N+1];
  logic signed [63:0] ry_r [N+1];
  logic signed [63:0] rz_r [N+1];

  // exponent difference
  logic [2:0]  s_idx, c_idx;
  logic [7:0]  s_byte, c_byte;
  logic [2:0]  m_sidx_r, m_cidx_r;
  logic [7:0]  m_sbyte_r, m_cbyte_r;
  logic signed [63:0] m_s1_r, m_c1_r, m_s2_r, m_c2_r;
  logic        m_bad1_r;
  logic [2:0]  s_pos, c_pos;
  logic signed [6:0] kd;
  logic signed [63:0] c_shift;

  // hyperbolic path
  logic signed [63:0] hx_r [N+1];
  logic signed [63:0] hy_r [N+1];
  logic signed [63:0] hz_r [N+1];

  // scale to the row
  logic signed [63:0] g_r;
  logic [63:0] gc;
  logic [63:0] ll_r, lh_r, hl_r, hh_r;
  logic [33:0] mid_r;
  logic [63:0] hs_r;
  logic [63:0] d_r;
  logic signed [65:0] yn;
  logic [5:0]  row_sh;
  logic [PIX_W-1:0] row;
  logic        row_clip;
  logic        polar_all;

  logic [PIX_W-1:0] ox_r, oy_r;
  logic             ovld_r, oclip_r;

  assign adv = !out_v_r || out_ch.ready;
  assign pop = adv && !empty;

  assign out_ch.valid        = out_v_r;
  assign out_ch.pixel_x      = ox_r;
  assign out_ch.pixel_y      = oy_r;
  assign out_ch.result_valid = ovld_r;
  assign out_ch.clipped      = oclip_r;

  assign size_m1 = PIX_W'((31'd1 << map_shift) - 31'd1);

  // stage valid flags, the whole pipe moves together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      vld_r   <= {vld_r[LAST-1:0], !empty};
      out_v_r <= vld_r[LAST];
    end
  end

  // side data entering from the queue
  always_comb begin
    side0_nxt.coord_valid = head.coord_valid;
    side0_nxt.north       = head.north;
    side0_nxt.polar       = head.polar;
    side0_nxt.col_clip    = head.col_lo || head.col_hi;
    side0_nxt.px          = '0;
    side0_nxt.k           = '0;
    side0_nxt.bad         = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv) side_r[0] <= side0_nxt;
  end

  // column and exponent results dropped into the side data
  always_comb begin
    side_col_nxt    = side_r[S_COL-1];
    side_col_nxt.px = c_lo2_r ? '0 : (c_hi2_r ? size_m1 : px_div[PIX_W-1:0]);
    side_k_nxt      = side_r[S_K-1];
    side_k_nxt.k    = kd[6] ? 3'd0 : kd[2:0];
    side_k_nxt.bad  = m_bad1_r || (kd > 7'sd6);
  end

  // side data shift line
  for (genvar s = 1; s <= LAST; s++) begin : g_side
    if (s == S_COL) begin : g_col
      always_ff @(posedge clk) begin
        if (adv) side_r[s] <= side_col_nxt;
      end
    end else if (s == S_K) begin : g_k
      always_ff @(posedge clk) begin
        if (adv) side_r[s] <= side_k_nxt;
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (adv) side_r[s] <= side_r[s-1];
      end
    end
  end

  // column: scale, reciprocal multiply, one correction step
  always_comb begin
    n_sh   = {30'd0, head.n_lon} << map_shift;
    c_sum  = {c_ph_r, 32'd0} + {5'd0, c_pl_r};
    est45  = ({7'd0, c_est_r} << 5) + ({7'd0, c_est_r} << 3) +
             ({7'd0, c_est_r} << 2) + {7'd0, c_est_r};
    c_rem  = {2'd0, c_q2_r} - est45;
    px_div = (c_rem >= {30'd0, COL_DIV}) ? c_est_r + 31'd1 : c_est_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_q_r   <= n_sh[60:25];
      c_lo_r  <= head.col_lo;
      c_hi_r  <= head.col_hi;
      c_pl_r  <= c_q_r[31:0] * COL_RECIP;
      c_ph_r  <= c_q_r[35:32] * COL_RECIP;
      c_q1_r  <= c_q_r;
      c_lo1_r <= c_lo_r;
      c_hi1_r <= c_hi_r;
      c_est_r <= c_sum[66:36];
      c_q2_r  <= c_q1_r;
      c_lo2_r <= c_lo1_r;
      c_hi2_r <= c_hi1_r;
    end
  end

  // latitude to radians in two partial products
  assign r_psum = {r_ph_r, 32'd0} + {28'd0, r_pl_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      r_pl_r  <= head.la * DEG2RAD_Q64[31:0];
      r_ph_r  <= head.la * DEG2RAD_Q64[63:32];
      rx_r[0] <= 64'sd1 <<< (FRAC - 2);
      ry_r[0] <= '0;
      rz_r[0] <= $signed(QUARTER_PI_Q + {19'd0, r_psum[87:43]});
    end
  end

  // circular rotation steps
  for (genvar j = 0; j < N; j++) begin : g_rot
    localparam int SH = j % 64;
    localparam logic signed [63:0] ATAN_K = atan_q(SH);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!rz_r[j][63]) begin
          rx_r[j+1] <= rx_r[j] - (ry_r[j] >>> SH);
          ry_r[j+1] <= ry_r[j] + (rx_r[j] >>> SH);
          rz_r[j+1] <= rz_r[j] - ATAN_K;
        end else begin
          rx_r[j+1] <= rx_r[j] + (ry_r[j] >>> SH);
          ry_r[j+1] <= ry_r[j] - (rx_r[j] >>> SH);
          rz_r[j+1] <= rz_r[j] + ATAN_K;
        end
      end
    end
  end

  // leading byte of sine and cosine
  always_comb begin
    s_idx = '0;
    c_idx = '0;
    for (int b = 0; b < 8; b++) begin
      if (|ry_r[N][8*b +: 8]) s_idx = 3'(b);
      if (|rx_r[N][8*b +: 8]) c_idx = 3'(b);
    end
    s_byte = ry_r[N][{s_idx, 3'b000} +: 8];
    c_byte = rx_r[N][{c_idx, 3'b000} +: 8];
  end

  // leading bit within the byte, exponent difference
  always_comb begin
    s_pos = '0;
    c_pos = '0;
    for (int b = 0; b < 8; b++) begin
      if (m_sbyte_r[b]) s_pos = 3'(b);
      if (m_cbyte_r[b]) c_pos = 3'(b);
    end
    kd = $signed({1'b0, m_sidx_r, s_pos}) - $signed({1'b0, m_cidx_r, c_pos});
  end

  assign c_shift = m_c2_r <<< side_r[S_K].k;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_sidx_r  <= s_idx;
      m_cidx_r  <= c_idx;
      m_sbyte_r <= s_byte;
      m_cbyte_r <= c_byte;
      m_s1_r    <= ry_r[N];
      m_c1_r    <= rx_r[N];
      m_bad1_r  <= (rx_r[N] <= 64'sd0) || (ry_r[N] <= 64'sd0);
      m_s2_r    <= m_s1_r;
      m_c2_r    <= m_c1_r;
      hx_r[0]   <= m_s2_r + c_shift;
      hy_r[0]   <= m_s2_r - c_shift;
      hz_r[0]   <= '0;
    end
  end

  // hyperbolic vectoring steps
  for (genvar j = 0; j < N; j++) begin : g_hyp
    localparam int SH = hyp_shift(j);
    localparam logic signed [63:0] ATANH_K = atanh_q(SH);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!hy_r[j][63]) begin
          hx_r[j+1] <= hx_r[j] - (hy_r[j] >>> SH);
          hy_r[j+1] <= hy_r[j] - (hx_r[j] >>> SH);
          hz_r[j+1] <= hz_r[j] + ATANH_K;
        end else begin
          hx_r[j+1] <= hx_r[j] + (hy_r[j] >>> SH);
          hy_r[j+1] <= hy_r[j] + (hx_r[j] >>> SH);
          hz_r[j+1] <= hz_r[j] - ATANH_K;
        end
      end
    end
  end

  // g, then g times 1/(2 pi) as a split 64x64 high word
  assign gc = g_r[63] ? 64'd0 : g_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      g_r   <= (hz_r[N] <<< 1) + $signed(LN2_Q * {61'd0, side_r[2*N+4].k});
      ll_r  <= gc[31:0] * INV2PI_Q64[31:0];
      lh_r  <= gc[31:0] * INV2PI_Q64[63:32];
      hl_r  <= gc[63:32] * INV2PI_Q64[31:0];
      hh_r  <= gc[63:32] * INV2PI_Q64[63:32];
      mid_r <= {2'd0, ll_r[63:32]} + {2'd0, lh_r[31:0]} + {2'd0, hl_r[31:0]};
      hs_r  <= hh_r + {32'd0, lh_r[63:32]} + {32'd0, hl_r[63:32]};
      d_r   <= hs_r + {62'd0, mid_r[33:32]};
    end
  end

  // row from the north edge, clamped
  always_comb begin
    polar_all = side_r[LAST].polar || side_r[LAST].bad;
    yn        = side_r[LAST].north ? HALF_Q - $signed({2'b00, d_r})
                                   : HALF_Q + $signed({2'b00, d_r});
    row_sh    = 6'(FRAC) - {1'b0, map_shift};
    row       = '0;
    row_clip  = 1'b0;
    if (polar_all) begin
      row      = side_r[LAST].north ? '0 : size_m1;
      row_clip = 1'b1;
    end else if (yn < 66'sd0) begin
      row_clip = 1'b1;
    end else if (yn >= ONE_Q) begin
      row      = size_m1;
      row_clip = 1'b1;
    end else begin
      row = PIX_W'(yn[FRAC-1:0] >> row_sh);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      if (side_r[LAST].coord_valid) begin
        ox_r    <= side_r[LAST].px;
        oy_r    <= row;
        ovld_r  <= 1'b1;
        oclip_r <= side_r[LAST].col_clip || row_clip;
      end else begin
        ox_r    <= '0;
        oy_r    <= '0;
        ovld_r  <= 1'b0;
        oclip_r <= 1'b0;
      end
    end
  end

endmodule

// ===== design/latlon_to_mercator_pixel_unit.sv =====
// a word passes the input register, the queue, both cordic pipelines and the row
// multiply to the output; throughput is one word per cycle unless the output stalls,
// and a 4-entry queue splits the input register from the back pipeline, which
// advances whenever its output register is empty or being taken
// reset: synchronous active-low rst_n clears all valid flags and the queue, zoom to 1
module latlon_to_mercator_pixel_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  lmp_in_if.sink                     in_ch,
  lmp_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [lmp_pkg::ZOOM_W-1:0] cfg_wdata
);
  import lmp_pkg::*;

  logic [ZOOM_W-1:0]  zoom_r;
  logic [SHIFT_W-1:0] map_shift;
  lmp_item_t          f_item;
  lmp_item_t          q_head;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;

  // zoom register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zoom_r <= ZOOM_RESET;
    end else if (cfg_we) begin
      zoom_r <= cfg_wdata;
    end
  end

  // map size exponent, zoom clamped to its top level
  assign map_shift = ((zoom_r > ZOOM_W'(MAX_ZOOM)) ? SHIFT_W'(MAX_ZOOM) : zoom_r)
                     + SHIFT_W'(TILE_LOG);

  lmp_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .item  (f_item),
    .push  (q_push),
    .full  (q_full)
  );

  lmp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  lmp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .map_shift (map_shift),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== design/lmp_checker.sv =====
module lmp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [lmp_pkg::PIX_W-1:0] pixel_x,
  input logic [lmp_pkg::PIX_W-1:0] pixel_y,
  input logic                      result_valid,
  input logic                      clipped
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a word without a valid result gives all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !result_valid |-> pixel_x == '0 && pixel_y == '0 && !clipped)
    else $error("invalid word carries nonzero fields");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(result_valid) && $stable(clipped))
    else $error("stalled output word changed");

endmodule

bind latlon_to_mercator_pixel_unit lmp_checker u_lmp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pixel_x      (out_ch.pixel_x),
  .pixel_y      (out_ch.pixel_y),
  .result_valid (out_ch.result_valid),
  .clipped      (out_ch.clipped)
);
